### rtl/core/gut_pkg.sv
// shared types and constants for the gaussian unit triple obstruction test
// no dependencies
`default_nettype none
package gut_pkg;

  // residue width and barrett constant width
  localparam int MB       = 12;
  localparam int MU_W     = 26;
  localparam int RED_K    = 26;
  localparam int CMUL_LAT = 4;
  localparam int N_STAGE  = 5 * CMUL_LAT;
  localparam int ORIENT_W = 28;

  // reset modulus and floor(2^26 / 3)
  localparam logic [MB-1:0]   MOD_RESET = 12'd3;
  localparam logic [MU_W-1:0] MU_RESET  = 26'd22369621;

  // configuration register indexes
  typedef enum logic {
    REG_MODULUS = 1'b0,
    REG_ORIENT  = 1'b1
  } reg_idx_t;

  // gaussian residue
  typedef struct packed {
    logic [MB-1:0] re;
    logic [MB-1:0] im;
  } gres_t;

  // complex conjugate mod l
  function automatic gres_t gconj(input gres_t x, input logic [MB-1:0] l);
    gres_t r;
    r.re = x.re;
    r.im = (x.im == '0) ? '0 : l - x.im;
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/gaussian_unit_triple_obstruction_test_top.sv
// gaussian unit triple obstruction test: residues, offsets and pattern search
// depends on gut_pkg and gut_cmul
//
// Usage: the host writes modulus and column_orientations through the cfg
// port (cfg_we, cfg_index, cfg_data) while nothing is in flight, then
// streams triples on the in_ channel (in_valid / in_stall). Each triple
// gives one result on the out_ channel (out_valid / out_stall).
// From the input transfer to out_valid a triple passes through five complex
// modular multiply groups of four stages each (norms and squares, fourth
// powers, two column products, offsets) and the result register, which
// also does the sign and swap search.
// Throughput is one triple per cycle; the whole pipeline holds while the
// result register is full and out_stall is high, so no item is lost.
// After a modulus write the barrett reciprocal is rebuilt by a serial
// divider; in_stall is high meanwhile. Reset loads modulus 3 with its
// reciprocal and zero orientations, and empties the pipe.
`default_nettype none
module gaussian_unit_triple_obstruction_test_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [27:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] in_pi_re,
  input  wire logic [11:0] in_pi_im,
  input  wire logic [11:0] in_beta_re,
  input  wire logic [11:0] in_beta_im,
  input  wire logic [11:0] in_gamma_re,
  input  wire logic [11:0] in_gamma_im,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_unit_triple,
  output logic             out_degenerate,
  output logic             out_solvable,
  output logic [4:0]       out_match_pattern,
  output logic [11:0]      out_offset_0,
  output logic [11:0]      out_offset_1,
  output logic [11:0]      out_offset_2,
  output logic [11:0]      out_offset_3
);

  localparam int MB = gut_pkg::MB;
  localparam int LT = gut_pkg::CMUL_LAT;

  typedef struct packed {
    logic          unit;
    gut_pkg::gres_t n1;
    gut_pkg::gres_t sq1;
    gut_pkg::gres_t n2;
    gut_pkg::gres_t sq2;
  } side2_t;

  typedef struct packed {
    logic          unit;
    gut_pkg::gres_t n2;
    gut_pkg::gres_t sq2;
  } side3_t;

  // configuration registers and reciprocal divider
  logic [MB-1:0]              mod_r;
  logic [gut_pkg::ORIENT_W-1:0] orient_r;
  logic [gut_pkg::MU_W-1:0]   mu_r;
  logic [MB-1:0]              rem_r;
  logic [4:0]                 div_cnt_r;
  logic [MB:0]                rem_s;
  logic                       dbit;
  logic                       mod_wr;
  logic                       ori_wr;

  assign dbit   = (div_cnt_r == 5'd27);
  assign rem_s  = {rem_r, dbit};
  assign mod_wr = cfg_we && (gut_pkg::reg_idx_t'(cfg_index) == gut_pkg::REG_MODULUS);
  assign ori_wr = cfg_we && (gut_pkg::reg_idx_t'(cfg_index) == gut_pkg::REG_ORIENT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r     <= gut_pkg::MOD_RESET;
      orient_r  <= '0;
      mu_r      <= gut_pkg::MU_RESET;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      // a modulus write restarts the reciprocal divider
      if (mod_wr) begin
        mod_r     <= cfg_data[MB-1:0];
        rem_r     <= '0;
        div_cnt_r <= 5'd27;
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - 5'd1;
        if (rem_s >= {1'b0, mod_r}) begin
          rem_r <= MB'(rem_s - {1'b0, mod_r});
          mu_r  <= {mu_r[gut_pkg::MU_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_s[MB-1:0];
          mu_r  <= {mu_r[gut_pkg::MU_W-2:0], 1'b0};
        end
      end
      if (ori_wr) orient_r <= cfg_data;
    end
  end

  // pipeline advance and valid chain
  logic                      en;
  logic                      out_valid_r;
  logic [gut_pkg::N_STAGE-1:0] vld_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en || (div_cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[gut_pkg::N_STAGE-2:0], in_valid && (div_cnt_r == '0)};
      out_valid_r <= vld_r[gut_pkg::N_STAGE-1];
    end
  end

  // group 1: norms and squares
  gut_pkg::gres_t x_in [3];
  gut_pkg::gres_t n_g1 [3];
  gut_pkg::gres_t sq_g1 [3];
  logic           rng;
  logic [LT-1:0]  rng_d_r;

  assign x_in[0] = '{re: in_pi_re,    im: in_pi_im};
  assign x_in[1] = '{re: in_beta_re,  im: in_beta_im};
  assign x_in[2] = '{re: in_gamma_re, im: in_gamma_im};
  assign rng = (in_pi_re < mod_r) && (in_pi_im < mod_r) && (in_beta_re < mod_r) &&
               (in_beta_im < mod_r) && (in_gamma_re < mod_r) && (in_gamma_im < mod_r);

  always_ff @(posedge clk) begin
    if (en) rng_d_r <= {rng_d_r[LT-2:0], rng};
  end

  for (genvar g = 0; g < 3; g++) begin : g_g1
    gut_cmul u_norm (.clk(clk), .en(en), .l(mod_r), .mu(mu_r), .a(x_in[g]),
                     .b(gut_pkg::gconj(x_in[g], mod_r)), .y(n_g1[g]));
    gut_cmul u_sq (.clk(clk), .en(en), .l(mod_r), .mu(mu_r), .a(x_in[g]),
                   .b(x_in[g]), .y(sq_g1[g]));
  end

  // group 2: powers of the first generator
  logic           unit1;
  side2_t         s2_in;
  side2_t         s2_r [LT];
  gut_pkg::gres_t pi_nn, pi_nsq, pi_q4;

  assign unit1 = rng_d_r[LT-1] && (n_g1[0].re != '0) && (n_g1[1].re != '0) &&
                 (n_g1[2].re != '0);
  assign s2_in = '{unit: unit1, n1: n_g1[1], sq1: sq_g1[1], n2: n_g1[2], sq2: sq_g1[2]};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r[0] <= s2_in;
      for (int i = 1; i < LT; i++) s2_r[i] <= s2_r[i-1];
    end
  end

  gut_cmul u_nn  (.clk(clk), .en(en), .l(mod_r), .mu(mu_r), .a(n_g1[0]), .b(n_g1[0]),
                  .y(pi_nn));
  gut_cmul u_nsq (.clk(clk), .en(en), .l(mod_r), .mu(mu_r), .a(n_g1[0]), .b(sq_g1[0]),
                  .y(pi_nsq));
  gut_cmul u_q4  (.clk(clk), .en(en), .l(mod_r), .mu(mu_r), .a(sq_g1[0]), .b(sq_g1[0]),
                  .y(pi_q4));

  // column factor selection
  function automatic gut_pkg::gres_t pick_p(input logic [2:0] code, input gut_pkg::gres_t nn,
                                            input gut_pkg::gres_t nsq,
                                            input gut_pkg::gres_t q4,
                                            input logic [MB-1:0] l);
    gut_pkg::gres_t r;
    unique case (code)
      3'd0:                r = nn;
      3'd1:                r = nsq;
      3'd2, 3'd3:          r = q4;
      3'd4, 3'd5, 3'd6:    r = gut_pkg::gconj(q4, l);
      default:             r = gut_pkg::gconj(nsq, l);
    endcase
    return r;
  endfunction

  function automatic gut_pkg::gres_t pick_q(input logic [1:0] code, input gut_pkg::gres_t n,
                                            input gut_pkg::gres_t sq,
                                            input logic [MB-1:0] l);
    gut_pkg::gres_t r;
    unique case (code)
      2'd0:    r = n;
      2'd1:    r = sq;
      default: r = gut_pkg::gconj(sq, l);
    endcase
    return r;
  endfunction

  // group 3: first and second factor per column
  side3_t         s3_r [LT];
  gut_pkg::gres_t pc [4];
  logic           unit4_r [LT];
  gut_pkg::gres_t zc [4];
  logic           unit5_r [LT];
  gut_pkg::gres_t vc [4];

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r[0] <= '{unit: s2_r[LT-1].unit, n2: s2_r[LT-1].n2, sq2: s2_r[LT-1].sq2};
      for (int i = 1; i < LT; i++) s3_r[i] <= s3_r[i-1];
      unit4_r[0] <= s3_r[LT-1].unit;
      for (int i = 1; i < LT; i++) unit4_r[i] <= unit4_r[i-1];
      unit5_r[0] <= unit4_r[LT-1];
      for (int i = 1; i < LT; i++) unit5_r[i] <= unit5_r[i-1];
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    gut_pkg::gres_t fa, fb, fc, dz;
    logic [MB:0]    dbl;

    assign fa = pick_p(orient_r[3*c+2:3*c], pi_nn, pi_nsq, pi_q4, mod_r);
    assign fb = pick_q(orient_r[12+2*c+1:12+2*c], s2_r[LT-1].n1, s2_r[LT-1].sq1, mod_r);
    gut_cmul u_ab (.clk(clk), .en(en), .l(mod_r), .mu(mu_r), .a(fa), .b(fb), .y(pc[c]));

    // group 4: third factor
    assign fc = pick_q(orient_r[20+2*c+1:20+2*c], s3_r[LT-1].n2, s3_r[LT-1].sq2, mod_r);
    gut_cmul u_abc (.clk(clk), .en(en), .l(mod_r), .mu(mu_r), .a(pc[c]), .b(fc),
                    .y(zc[c]));

    // group 5: offset 2ab mod l
    assign dbl = {zc[c].re, 1'b0};
    assign dz  = '{re: (dbl >= {1'b0, mod_r}) ? MB'(dbl - {1'b0, mod_r}) : dbl[MB-1:0],
                   im: '0};
    gut_cmul u_off (.clk(clk), .en(en), .l(mod_r), .mu(mu_r), .a(dz),
                    .b('{re: zc[c].im, im: '0}), .y(vc[c]));
  end

  // sign and swap search
  function automatic logic [MB-1:0] mneg(input logic [MB-1:0] x, input logic [MB-1:0] l);
    return (x == '0) ? '0 : l - x;
  endfunction

  function automatic logic [MB-1:0] madd(input logic [MB-1:0] x, input logic [MB-1:0] y,
                                         input logic [MB-1:0] l);
    logic [MB:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, l}) ? MB'(s - {1'b0, l}) : s[MB-1:0];
  endfunction

  logic       found;
  logic [4:0] pat;
  logic       degen;

  always_comb begin
    logic [MB-1:0] a, b, s, d, se, de, lsum, ldif;
    found = 1'b0;
    pat   = '0;
    for (int k = 31; k >= 0; k--) begin
      se   = k[4] ? vc[3].re : vc[2].re;
      de   = k[4] ? vc[2].re : vc[3].re;
      a    = k[3] ? vc[0].re : mneg(vc[0].re, mod_r);
      b    = k[2] ? vc[1].re : mneg(vc[1].re, mod_r);
      s    = k[1] ? se : mneg(se, mod_r);
      d    = k[0] ? de : mneg(de, mod_r);
      lsum = madd(a, b, mod_r);
      ldif = madd(a, mneg(b, mod_r), mod_r);
      if (s == lsum && d == ldif) begin
        found = 1'b1;
        pat   = 5'(k);
      end
    end
  end

  assign degen = (vc[0].re == '0) && (vc[1].re == '0) && (vc[2].re == '0) &&
                 (vc[3].re == '0);

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      out_is_unit_triple <= unit5_r[LT-1];
      out_degenerate     <= unit5_r[LT-1] && degen;
      out_solvable       <= unit5_r[LT-1] && !degen && found;
      out_match_pattern  <= (unit5_r[LT-1] && !degen) ? pat : '0;
      out_offset_0       <= (unit5_r[LT-1] && !degen) ? vc[0].re : '0;
      out_offset_1       <= (unit5_r[LT-1] && !degen) ? vc[1].re : '0;
      out_offset_2       <= (unit5_r[LT-1] && !degen) ? vc[2].re : '0;
      out_offset_3       <= (unit5_r[LT-1] && !degen) ? vc[3].re : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/core/gut_cmul.sv
// pipelined complex multiply mod l with barrett reduction, four stages
// depends on gut_pkg
`default_nettype none
module gut_cmul (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [gut_pkg::MB-1:0]  l,
  input  wire logic [gut_pkg::MU_W-1:0] mu,
  input  wire gut_pkg::gres_t          a,
  input  wire gut_pkg::gres_t          b,
  output gut_pkg::gres_t               y
);

  localparam int TW = 2 * gut_pkg::MB + 1;
  localparam int PW = TW + gut_pkg::MU_W;
  localparam int QW = PW - gut_pkg::RED_K;
  localparam int RW = gut_pkg::MB + 3;

  logic [TW-1:0] t1_re_r, t1_im_r, t2_re_r, t2_im_r, t3_re_r, t3_im_r;
  logic [PW-1:0] p_re_r, p_im_r;
  logic [QW+gut_pkg::MB-1:0] qp_re_r, qp_im_r;
  logic [gut_pkg::MB-1:0] nbi;
  logic [RW-1:0] r_re, r_im;

  function automatic logic [gut_pkg::MB-1:0] fix(input logic [RW-1:0] r,
                                                 input logic [gut_pkg::MB-1:0] m);
    logic [RW-1:0] s;
    s = r;
    if (s >= {3'b0, m}) s = s - {3'b0, m};
    if (s >= {3'b0, m}) s = s - {3'b0, m};
    return s[gut_pkg::MB-1:0];
  endfunction

  assign nbi = l - b.im;

  // stage 1: raw products
  always_ff @(posedge clk) begin
    if (en) begin
      t1_re_r <= TW'(a.re) * TW'(b.re) + TW'(a.im) * TW'(nbi);
      t1_im_r <= TW'(a.re) * TW'(b.im) + TW'(a.im) * TW'(b.re);
    end
  end

  // stage 2: multiply by reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      p_re_r  <= PW'(t1_re_r) * PW'(mu);
      p_im_r  <= PW'(t1_im_r) * PW'(mu);
      t2_re_r <= t1_re_r;
      t2_im_r <= t1_im_r;
    end
  end

  // stage 3: quotient estimate times modulus
  always_ff @(posedge clk) begin
    if (en) begin
      qp_re_r <= (QW+gut_pkg::MB)'(p_re_r[PW-1:gut_pkg::RED_K]) * (QW+gut_pkg::MB)'(l);
      qp_im_r <= (QW+gut_pkg::MB)'(p_im_r[PW-1:gut_pkg::RED_K]) * (QW+gut_pkg::MB)'(l);
      t3_re_r <= t2_re_r;
      t3_im_r <= t2_im_r;
    end
  end

  // stage 4: remainder and correction
  assign r_re = RW'(t3_re_r) - qp_re_r[RW-1:0];
  assign r_im = RW'(t3_im_r) - qp_im_r[RW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      y.re <= fix(r_re, l);
      y.im <= fix(r_im, l);
    end
  end

endmodule
`default_nettype wire
